// File: hdl/lifn_pkg.sv
// ----------------------------------------------------------------------------
// lifn_pkg
// Shared types, constants and helpers for the leaky integrate-and-fire
// neuron array step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lifn_pkg;

    // default array size
    localparam int unsigned NEURONS_DEFAULT = 1024;

    // field widths
    localparam int unsigned NEURON_W = 10;
    localparam int unsigned TIME_W   = 24;
    localparam int unsigned KICK_W   = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned REFR_W   = 8;
    localparam int unsigned LEVEL_W  = 31;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register reset values
    localparam logic [COEF_W-1:0]  MEMBRANE_DECAY_RST    = 16'd65209;
    localparam logic [COEF_W-1:0]  CONDUCTANCE_DECAY_RST = 16'd64238;
    localparam logic [COEF_W-1:0]  COUPLING_GAIN_RST     = 16'd324;
    localparam logic [REFR_W-1:0]  REFRACTORY_STEPS_RST  = 8'd22;
    localparam logic [LEVEL_W-1:0] FIRE_THRESHOLD_RST    = 31'd458752;
    localparam logic [LEVEL_W-1:0] KICK_AMOUNT_RST       = 31'd4505600;

    // largest ready time
    localparam logic [TIME_W-1:0] READY_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEMBRANE_DECAY    = 3'd0,
        REG_CONDUCTANCE_DECAY = 3'd1,
        REG_COUPLING_GAIN     = 3'd2,
        REG_REFRACTORY_STEPS  = 3'd3,
        REG_FIRE_THRESHOLD    = 3'd4,
        REG_KICK_AMOUNT       = 3'd5
    } t_reg_idx;

    // operation codes
    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    // configuration register set
    typedef struct packed {
        logic [COEF_W-1:0]  membrane_decay;
        logic [COEF_W-1:0]  conductance_decay;
        logic [COEF_W-1:0]  coupling_gain;
        logic [REFR_W-1:0]  refractory_steps;
        logic [LEVEL_W-1:0] fire_threshold;
        logic [LEVEL_W-1:0] kick_amount;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic mul;
        logic sum;
        logic kick;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    // saturate a wide signed sum to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat32(input logic signed [36:0] x);
        logic [DATA_W-1:0] res;
        if (x > 37'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (x < -37'sh0_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lifn_cfg.sv
// ----------------------------------------------------------------------------
// lifn_cfg
// Configuration register file; takes one write transaction per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lifn_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [lifn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lifn_pkg::DATA_W-1:0]    i_cfg_data,
    output      lifn_pkg::t_cfg                o_cfg
);

    lifn_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.membrane_decay    <= lifn_pkg::MEMBRANE_DECAY_RST;
            r_cfg.conductance_decay <= lifn_pkg::CONDUCTANCE_DECAY_RST;
            r_cfg.coupling_gain     <= lifn_pkg::COUPLING_GAIN_RST;
            r_cfg.refractory_steps  <= lifn_pkg::REFRACTORY_STEPS_RST;
            r_cfg.fire_threshold    <= lifn_pkg::FIRE_THRESHOLD_RST;
            r_cfg.kick_amount       <= lifn_pkg::KICK_AMOUNT_RST;
        end else if (i_cfg_valid) begin
            case (lifn_pkg::t_reg_idx'(i_cfg_index))
                lifn_pkg::REG_MEMBRANE_DECAY:
                    r_cfg.membrane_decay <= i_cfg_data[lifn_pkg::COEF_W-1:0];
                lifn_pkg::REG_CONDUCTANCE_DECAY:
                    r_cfg.conductance_decay <= i_cfg_data[lifn_pkg::COEF_W-1:0];
                lifn_pkg::REG_COUPLING_GAIN:
                    r_cfg.coupling_gain <= i_cfg_data[lifn_pkg::COEF_W-1:0];
                lifn_pkg::REG_REFRACTORY_STEPS:
                    r_cfg.refractory_steps <= i_cfg_data[lifn_pkg::REFR_W-1:0];
                lifn_pkg::REG_FIRE_THRESHOLD:
                    r_cfg.fire_threshold <= i_cfg_data[lifn_pkg::LEVEL_W-1:0];
                lifn_pkg::REG_KICK_AMOUNT:
                    r_cfg.kick_amount <= i_cfg_data[lifn_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/lifn_dp.sv
// ----------------------------------------------------------------------------
// lifn_dp
// Neuron state memories and the update arithmetic: read, multiply, sum,
// kick and commit stages driven by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lifn_dp #(
    parameter int unsigned NEURONS = lifn_pkg::NEURONS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lifn_pkg::t_dp_cmd             i_cmd,
    output      lifn_pkg::t_dp_status          o_status,
    input  wire lifn_pkg::t_cfg                i_cfg,
    input  wire logic                          i_command,
    input  wire logic [lifn_pkg::NEURON_W-1:0] i_neuron,
    input  wire logic [lifn_pkg::DATA_W-1:0]   i_amount,
    input  wire logic [lifn_pkg::TIME_W-1:0]   i_time_step,
    input  wire logic [lifn_pkg::KICK_W-1:0]   i_kick_count,
    input  wire logic                          i_input_neuron,
    output      logic                          o_spiked,
    output      logic [lifn_pkg::DATA_W-1:0]   o_membrane
);

    localparam int unsigned AW = $clog2(NEURONS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);
    localparam logic [16:0]   DEPTH     = 17'(NEURONS);

    // state memories
    logic [lifn_pkg::DATA_W-1:0] r_membrane_mem    [NEURONS];
    logic [lifn_pkg::DATA_W-1:0] r_conductance_mem [NEURONS];
    logic [lifn_pkg::TIME_W-1:0] r_ready_mem       [NEURONS];

    // clearing pass counter
    logic [AW-1:0] r_clr_addr;

    // captured transaction
    logic                          r_command;
    logic [AW-1:0]                 r_addr;
    logic                          r_in_range;
    logic [lifn_pkg::DATA_W-1:0]   r_amount;
    logic [lifn_pkg::TIME_W-1:0]   r_time;
    logic [lifn_pkg::KICK_W-1:0]   r_kicks;
    logic                          r_input;

    // read data
    logic [lifn_pkg::DATA_W-1:0]   r_mem_v;
    logic [lifn_pkg::DATA_W-1:0]   r_mem_g;
    logic [lifn_pkg::TIME_W-1:0]   r_mem_r;

    // products
    logic signed [48:0]            r_prod_v;
    logic signed [48:0]            r_prod_gc;
    logic signed [48:0]            r_prod_gd;
    logic [34:0]                   r_prod_k;
    logic                          r_active;

    // sum and kick results
    logic [lifn_pkg::DATA_W-1:0]   r_v1;
    logic [lifn_pkg::DATA_W-1:0]   r_g1;
    logic [lifn_pkg::DATA_W-1:0]   r_v2;
    logic                          r_fire;
    logic [lifn_pkg::TIME_W-1:0]   r_ready_new;

    // combinational stage values
    logic signed [36:0]            n_leak_sum;
    logic signed [36:0]            n_dep_sum;
    logic signed [36:0]            n_kick_sum;
    logic [lifn_pkg::DATA_W-1:0]   n_v2;
    logic [lifn_pkg::TIME_W:0]     n_ready_sum;
    logic [lifn_pkg::TIME_W-1:0]   n_refr;
    logic [AW-1:0]                 n_wr_addr;
    logic [lifn_pkg::DATA_W-1:0]   n_wr_v;
    logic [lifn_pkg::DATA_W-1:0]   n_wr_g;
    logic                          n_wr_en;

    assign o_status.clear_last = (r_clr_addr == LAST_ADDR);

    // arithmetic between stages
    always_comb begin
        n_leak_sum = 37'($signed(r_prod_v[48:16])) + 37'($signed(r_prod_gc[48:16]));
        n_dep_sum  = 37'($signed(r_mem_g)) + 37'($signed(r_amount));
        n_kick_sum = 37'($signed(r_v1)) + $signed({2'b00, r_prod_k});
        n_v2       = (r_command == lifn_pkg::CMD_STEP) ?
                     lifn_pkg::sat32(n_kick_sum) : r_v1;
        n_refr      = r_input ? '0 : lifn_pkg::TIME_W'(i_cfg.refractory_steps);
        n_ready_sum = {1'b0, r_time} + {1'b0, n_refr};
    end

    // write port shared by the clearing pass and the commit stage
    always_comb begin
        n_wr_en   = i_cmd.clear_step || (i_cmd.commit && r_in_range);
        n_wr_addr = i_cmd.clear_step ? r_clr_addr : r_addr;
        n_wr_v    = (i_cmd.clear_step || r_fire) ? '0 : r_v2;
        n_wr_g    = (i_cmd.clear_step || r_fire) ? '0 : r_g1;
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_membrane_mem[n_wr_addr]    <= n_wr_v;
            r_conductance_mem[n_wr_addr] <= n_wr_g;
        end
        if (i_cmd.clear_step) begin
            r_ready_mem[n_wr_addr] <= '0;
        end else if (i_cmd.commit && r_in_range && r_fire) begin
            r_ready_mem[n_wr_addr] <= r_ready_new;
        end
        if (i_cmd.read) begin
            r_mem_v <= r_membrane_mem[r_addr];
            r_mem_g <= r_conductance_mem[r_addr];
            r_mem_r <= r_ready_mem[r_addr];
        end
    end

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command  <= i_command;
            r_addr     <= AW'(i_neuron);
            r_in_range <= (17'(i_neuron) < DEPTH);
            r_amount   <= i_amount;
            r_time     <= i_time_step;
            r_kicks    <= i_kick_count;
            r_input    <= i_input_neuron;
        end
        // products, floored later by dropping 16 fraction bits
        if (i_cmd.mul) begin
            r_prod_v  <= $signed(r_mem_v) * $signed({1'b0, i_cfg.membrane_decay});
            r_prod_gc <= $signed(r_mem_g) * $signed({1'b0, i_cfg.coupling_gain});
            r_prod_gd <= $signed(r_mem_g) * $signed({1'b0, i_cfg.conductance_decay});
            r_prod_k  <= r_kicks * i_cfg.kick_amount;
            r_active  <= (r_time >= r_mem_r);
        end
        // leak and coupling, or conductance deposit
        if (i_cmd.sum) begin
            if (r_command == lifn_pkg::CMD_DEPOSIT) begin
                r_v1 <= r_mem_v;
                r_g1 <= lifn_pkg::sat32(n_dep_sum);
            end else if (r_active) begin
                r_v1 <= lifn_pkg::sat32(n_leak_sum);
                r_g1 <= r_prod_gd[47:16];
            end else begin
                r_v1 <= r_mem_v;
                r_g1 <= r_mem_g;
            end
        end
        // kicks and threshold test
        if (i_cmd.kick) begin
            r_v2   <= n_v2;
            r_fire <= (r_command == lifn_pkg::CMD_STEP) && r_active &&
                      ($signed(n_v2) > $signed({1'b0, i_cfg.fire_threshold}));
            r_ready_new <= n_ready_sum[lifn_pkg::TIME_W] ? lifn_pkg::READY_MAX :
                           n_ready_sum[lifn_pkg::TIME_W-1:0];
        end
        // result register
        if (i_cmd.commit) begin
            o_spiked   <= r_in_range && r_fire;
            o_membrane <= (r_in_range && !r_fire) ? r_v2 : '0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lifn_ctrl.sv
// ----------------------------------------------------------------------------
// lifn_ctrl
// Sequencer: clearing pass after reset, then one transaction at a time
// through read, multiply, sum, kick and commit; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lifn_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      lifn_pkg::t_dp_cmd    o_cmd,
    input  wire lifn_pkg::t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_KICK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_commit;

    assign n_commit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // datapath commands
    assign o_cmd.clear_step = (r_state == S_CLEAR);
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.read       = (r_state == S_READ);
    assign o_cmd.mul        = (r_state == S_MUL);
    assign o_cmd.sum        = (r_state == S_SUM);
    assign o_cmd.kick       = (r_state == S_KICK);
    assign o_cmd.commit     = n_commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_status.clear_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_KICK;
            S_KICK:  n_state = S_DONE;
            S_DONE:  if (n_commit) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while pending");

    // a captured transaction always starts its read next
    a_capture_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_READ))
        else $error("capture not followed by read");

    // no transaction accepted during the clearing pass
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // a new result only comes from the commit stage
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result valid raised outside commit");

endmodule

`default_nettype wire

// File: hdl/lif_neuron_array_step.sv
// ----------------------------------------------------------------------------
// lif_neuron_array_step
// Leaky integrate-and-fire neuron array with exponential synapses, Q16.16.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every entry of the membrane,
// conductance and ready memories and accepts no transaction until it ends;
// configuration writes are taken at any time. Each transaction then passes
// through accept, memory read, multiply, sum, kick and threshold, and commit,
// and the block takes no new transaction until it has committed, because
// every neuron update is a read-modify-write of one memory entry done by a
// single sequenced datapath. The result sits in an output register, and the
// next transaction is accepted while it waits to be taken; the commit of that
// next transaction waits until the register is free.
`default_nettype none

module lif_neuron_array_step #(
    parameter int unsigned NEURONS = lifn_pkg::NEURONS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic [lifn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lifn_pkg::DATA_W-1:0]    i_cfg_data,
    // input transaction
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic                           i_command,
    input  wire logic [lifn_pkg::NEURON_W-1:0]  i_neuron,
    input  wire logic [lifn_pkg::DATA_W-1:0]    i_amount,
    input  wire logic [lifn_pkg::TIME_W-1:0]    i_time_step,
    input  wire logic [lifn_pkg::KICK_W-1:0]    i_kick_count,
    input  wire logic                           i_input_neuron,
    // result transaction
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic                           o_spiked,
    output      logic [lifn_pkg::DATA_W-1:0]    o_membrane
);

    lifn_pkg::t_cfg       cfg;
    lifn_pkg::t_dp_cmd    dp_cmd;
    lifn_pkg::t_dp_status dp_status;

    // configuration registers
    lifn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // sequencer
    lifn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // memories and arithmetic
    lifn_dp #(
        .NEURONS (NEURONS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cfg          (cfg),
        .i_command      (i_command),
        .i_neuron       (i_neuron),
        .i_amount       (i_amount),
        .i_time_step    (i_time_step),
        .i_kick_count   (i_kick_count),
        .i_input_neuron (i_input_neuron),
        .o_spiked       (o_spiked),
        .o_membrane     (o_membrane)
    );

endmodule

`default_nettype wire

// File: test/tb_lif_neuron_array_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lif_neuron_array_step
// Self-checking testbench for the leaky integrate-and-fire neuron array step.
// A directed table covers reset state, saturation, refractory, input neurons
// and ready-time overflow, then constrained-by-hand random phases run under
// several register settings. Every result transaction is compared field by
// field with the typed table result or a cycle-free neuron array model.
// ----------------------------------------------------------------------------
module tb_lif_neuron_array_step;

    localparam int unsigned NEURONS        = lifn_pkg::NEURONS_DEFAULT;
    localparam int unsigned DIRECTED_ROWS  = 21;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned PHASE_ITEMS    = 65;
    localparam int unsigned PRESSURE_PHASE = 3;
    localparam int unsigned CALM_PHASE     = 4;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned DRAIN_LIMIT    = 5000;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam longint      LEVEL_MAX      = 2147483647;
    localparam longint      LEVEL_MIN      = -LEVEL_MAX - 1;
    localparam logic        TYPED          = 1'b1;
    localparam logic        PRED           = 1'b0;

    typedef struct packed {
        logic                          command;
        logic [lifn_pkg::NEURON_W-1:0] neuron;
        logic [lifn_pkg::DATA_W-1:0]   amount;
        logic [lifn_pkg::TIME_W-1:0]   time_step;
        logic [lifn_pkg::KICK_W-1:0]   kick_count;
        logic                          input_neuron;
    } t_neuron_op;

    typedef struct packed {
        logic                        spiked;
        logic [lifn_pkg::DATA_W-1:0] membrane;
    } t_neuron_result;

    typedef struct packed {
        t_neuron_op     op;
        logic           typed;
        t_neuron_result result;
    } t_directed_row;

    // directed table, run under the reset register values
    localparam t_directed_row DIRECTED_OPS [DIRECTED_ROWS] = '{
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd0,    32'h00000000, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd1,    32'h00000000, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd2,    32'h7FFFFFFF, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd2,    32'h7FFFFFFF, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd2,    32'h00000000, 24'd5,      4'd0,  1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd2,    32'h00000000, 24'd6,      4'd15, 1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd2,    32'h00010000, 24'd6,      4'd0,  1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd2,    32'h00000000, 24'd27,     4'd0,  1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd3,    32'h80000000, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd3,    32'h80000000, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd3,    32'h00000000, 24'd0,      4'd0,  1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd4,    32'h00000000, 24'd0,      4'd15, 1'b1},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd4,    32'h00000000, 24'd0,      4'd1,  1'b1},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd5,    32'h00000000, 24'hFFFFFF, 4'd1,  1'b0},
      TYPED, '{1'b1, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd5,    32'h00000000, 24'hFFFFFF, 4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd5,    32'h00000000, 24'hFFFFFE, 4'd15, 1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_DEPOSIT, 10'd1023, 32'hFFFFFFFF, 24'd0,      4'd0,  1'b0},
      TYPED, '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd1023, 32'h00000000, 24'h7FFFFF, 4'd0,  1'b1},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd6,    32'h00000000, 24'd100,    4'd8,  1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd6,    32'h00000000, 24'd110,    4'd2,  1'b0},
      PRED,  '{1'b0, 32'h0}},
    '{'{lifn_pkg::CMD_STEP,    10'd6,    32'h00000000, 24'd122,    4'd0,  1'b0},
      PRED,  '{1'b0, 32'h0}}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [lifn_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [lifn_pkg::DATA_W-1:0]    i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_command;
    logic [lifn_pkg::NEURON_W-1:0]  i_neuron;
    logic [lifn_pkg::DATA_W-1:0]    i_amount;
    logic [lifn_pkg::TIME_W-1:0]    i_time_step;
    logic [lifn_pkg::KICK_W-1:0]    i_kick_count;
    logic                           i_input_neuron;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic                           o_spiked;
    logic [lifn_pkg::DATA_W-1:0]    o_membrane;

    // mirror of the neuron array and its registers
    logic signed [lifn_pkg::DATA_W-1:0] membrane_mem [NEURONS];
    logic signed [lifn_pkg::DATA_W-1:0] conductance_mem [NEURONS];
    logic [lifn_pkg::TIME_W-1:0]        ready_mem [NEURONS];
    lifn_pkg::t_cfg                     settings;

    t_neuron_result               expected_results [$];
    int unsigned                  errors;
    logic [lifn_pkg::TIME_W-1:0]  sim_now;
    logic                         calm;
    logic                         hold_req;

    lif_neuron_array_step #(
        .NEURONS(NEURONS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_neuron       (i_neuron),
        .i_amount       (i_amount),
        .i_time_step    (i_time_step),
        .i_kick_count   (i_kick_count),
        .i_input_neuron (i_input_neuron),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_spiked       (o_spiked),
        .o_membrane     (o_membrane)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // signed q16.16 level times unsigned q0.16 coefficient, floored
    function automatic longint scale_q16(input logic signed [lifn_pkg::DATA_W-1:0] level,
                                         input logic [lifn_pkg::COEF_W-1:0] coef);
        longint prod;
        prod = longint'(level) * longint'({1'b0, coef});
        return prod >>> 16;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [lifn_pkg::DATA_W-1:0] clamp_level(input longint x);
        if (x > LEVEL_MAX) begin
            return lifn_pkg::DATA_W'(LEVEL_MAX);
        end else if (x < LEVEL_MIN) begin
            return lifn_pkg::DATA_W'(LEVEL_MIN);
        end
        return lifn_pkg::DATA_W'(x);
    endfunction

    // apply one operation to the mirror and return the expected result
    function automatic t_neuron_result apply_neuron_op(input t_neuron_op op);
        t_neuron_result                     res;
        logic signed [lifn_pkg::DATA_W-1:0] v;
        logic signed [lifn_pkg::DATA_W-1:0] g;
        logic                               active;
        longint                             ready_next;
        res = '0;
        if (op.neuron >= NEURONS) begin
            return res;
        end
        v = membrane_mem[op.neuron];
        g = conductance_mem[op.neuron];
        if (op.command == lifn_pkg::CMD_DEPOSIT) begin
            conductance_mem[op.neuron] =
                clamp_level(longint'(g) + longint'($signed(op.amount)));
        end else begin
            active = (op.time_step >= ready_mem[op.neuron]);
            // leak and coupling only outside the refractory window
            if (active) begin
                v = clamp_level(scale_q16(v, settings.membrane_decay) +
                                scale_q16(g, settings.coupling_gain));
                g = lifn_pkg::DATA_W'(scale_q16(g, settings.conductance_decay));
            end
            v = clamp_level(longint'(v) +
                            longint'(op.kick_count) * longint'(settings.kick_amount));
            // spike clears the neuron and sets its ready time
            if (active && longint'(v) > longint'(settings.fire_threshold)) begin
                res.spiked = 1'b1;
                v = '0;
                g = '0;
                ready_next = longint'(op.time_step) +
                             (op.input_neuron ? 64'sd0 : longint'(settings.refractory_steps));
                ready_mem[op.neuron] = (ready_next > longint'(lifn_pkg::READY_MAX)) ?
                                       lifn_pkg::READY_MAX :
                                       lifn_pkg::TIME_W'(ready_next);
            end
            membrane_mem[op.neuron]    = v;
            conductance_mem[op.neuron] = g;
        end
        res.membrane = v;
        return res;
    endfunction

    // register write into the mirror
    function automatic void store_setting(input lifn_pkg::t_reg_idx idx,
                                          input logic [lifn_pkg::DATA_W-1:0] data);
        case (idx)
            lifn_pkg::REG_MEMBRANE_DECAY:
                settings.membrane_decay    = data[lifn_pkg::COEF_W-1:0];
            lifn_pkg::REG_CONDUCTANCE_DECAY:
                settings.conductance_decay = data[lifn_pkg::COEF_W-1:0];
            lifn_pkg::REG_COUPLING_GAIN:
                settings.coupling_gain     = data[lifn_pkg::COEF_W-1:0];
            lifn_pkg::REG_REFRACTORY_STEPS:
                settings.refractory_steps  = data[lifn_pkg::REFR_W-1:0];
            lifn_pkg::REG_FIRE_THRESHOLD:
                settings.fire_threshold    = data[lifn_pkg::LEVEL_W-1:0];
            lifn_pkg::REG_KICK_AMOUNT:
                settings.kick_amount       = data[lifn_pkg::LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    // register value with random junk above its width
    function automatic logic [lifn_pkg::DATA_W-1:0] setting_word(input int unsigned value,
                                                                 input int unsigned width);
        logic [lifn_pkg::DATA_W-1:0] junk;
        junk = $urandom();
        return (junk << width) | lifn_pkg::DATA_W'(value);
    endfunction

    // register set for each phase: all ones, all zeros, reset values, random
    function automatic logic [5:0][lifn_pkg::DATA_W-1:0] phase_settings(input int unsigned ph);
        logic [5:0][lifn_pkg::DATA_W-1:0] v;
        case (ph)
            0: v = '1;
            1: v = '0;
            2: begin
                v[lifn_pkg::REG_MEMBRANE_DECAY] =
                    setting_word(lifn_pkg::MEMBRANE_DECAY_RST, lifn_pkg::COEF_W);
                v[lifn_pkg::REG_CONDUCTANCE_DECAY] =
                    setting_word(lifn_pkg::CONDUCTANCE_DECAY_RST, lifn_pkg::COEF_W);
                v[lifn_pkg::REG_COUPLING_GAIN] =
                    setting_word(lifn_pkg::COUPLING_GAIN_RST, lifn_pkg::COEF_W);
                v[lifn_pkg::REG_REFRACTORY_STEPS] =
                    setting_word(lifn_pkg::REFRACTORY_STEPS_RST, lifn_pkg::REFR_W);
                v[lifn_pkg::REG_FIRE_THRESHOLD] =
                    setting_word(lifn_pkg::FIRE_THRESHOLD_RST, lifn_pkg::LEVEL_W);
                v[lifn_pkg::REG_KICK_AMOUNT] =
                    setting_word(lifn_pkg::KICK_AMOUNT_RST, lifn_pkg::LEVEL_W);
            end
            default: begin
                v[lifn_pkg::REG_MEMBRANE_DECAY] =
                    setting_word($urandom_range(60000, 65535), lifn_pkg::COEF_W);
                v[lifn_pkg::REG_CONDUCTANCE_DECAY] =
                    setting_word($urandom_range(0, 65535), lifn_pkg::COEF_W);
                v[lifn_pkg::REG_COUPLING_GAIN] =
                    setting_word($urandom_range(0, 8000), lifn_pkg::COEF_W);
                v[lifn_pkg::REG_REFRACTORY_STEPS] =
                    setting_word($urandom_range(0, 255), lifn_pkg::REFR_W);
                v[lifn_pkg::REG_FIRE_THRESHOLD] =
                    setting_word($urandom_range(0, 16 << 16), lifn_pkg::LEVEL_W);
                v[lifn_pkg::REG_KICK_AMOUNT] =
                    setting_word($urandom_range(0, 8 << 16), lifn_pkg::LEVEL_W);
            end
        endcase
        return v;
    endfunction

    // random operation: mostly a small neuron pool on a rising time base,
    // some noise on neurons 32 to 1023 with arbitrary times
    function automatic t_neuron_op random_op();
        t_neuron_op op;
        op.command      = 1'($urandom_range(1));
        op.input_neuron = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       op.amount = 32'h7FFF_FFFF;
            1:       op.amount = 32'h8000_0000;
            2, 3:    op.amount = $urandom();
            default: op.amount = $urandom_range(0, 8 << 16) - (4 << 16);
        endcase
        op.kick_count = ($urandom_range(3) == 0) ?
                        lifn_pkg::KICK_W'($urandom_range(15)) :
                        lifn_pkg::KICK_W'($urandom_range(1));
        if ($urandom_range(99) < 4) begin
            op.neuron    = lifn_pkg::NEURON_W'($urandom_range(32, 1023));
            op.time_step = lifn_pkg::TIME_W'($urandom());
        end else begin
            op.neuron    = lifn_pkg::NEURON_W'($urandom_range(8, 23));
            op.time_step = sim_now;
            if (op.command == lifn_pkg::CMD_STEP) begin
                sim_now = sim_now + lifn_pkg::TIME_W'($urandom_range(3));
            end
        end
        return op;
    endfunction

    // offer one input transaction and record its expected result
    task automatic offer_op(input t_neuron_op op, input logic typed,
                            input t_neuron_result typed_res);
        t_neuron_result predicted;
        while (!calm && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= op.command;
        i_neuron       <= op.neuron;
        i_amount       <= op.amount;
        i_time_step    <= op.time_step;
        i_kick_count   <= op.kick_count;
        i_input_neuron <= op.input_neuron;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = apply_neuron_op(op);
        expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
    endtask

    // stop offering and wait for all pending results
    task automatic await_drained();
        int unsigned n;
        i_in_valid <= 1'b0;
        n = 0;
        while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // write all registers in index order
    task automatic load_settings(input logic [5:0][lifn_pkg::DATA_W-1:0] values);
        lifn_pkg::t_reg_idx idx;
        idx = idx.first();
        do begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= values[idx];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            store_setting(idx, values[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_valid <= 1'b0;
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_result();
        t_neuron_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result transaction: spiked %0d membrane %h",
                   o_spiked, o_membrane);
            errors++;
        end else begin
            want = expected_results.pop_front();
            if (o_spiked !== want.spiked) begin
                $error("spiked: expected %0d, actual %0d", want.spiked, o_spiked);
                errors++;
            end
            if (o_membrane !== want.membrane) begin
                $error("membrane: expected %h, actual %h", want.membrane, o_membrane);
                errors++;
            end
        end
    endtask

    // result sink with random stalls and a long hold-off on request
    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                check_result();
            end
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = lifn_pkg::REG_MEMBRANE_DECAY;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_command      = lifn_pkg::CMD_DEPOSIT;
        i_neuron       = '0;
        i_amount       = '0;
        i_time_step    = '0;
        i_kick_count   = '0;
        i_input_neuron = 1'b0;
        errors         = 0;
        sim_now        = 24'd200;
        calm           = 1'b0;
        hold_req       = 1'b0;
        settings       = '{membrane_decay:    lifn_pkg::MEMBRANE_DECAY_RST,
                           conductance_decay: lifn_pkg::CONDUCTANCE_DECAY_RST,
                           coupling_gain:     lifn_pkg::COUPLING_GAIN_RST,
                           refractory_steps:  lifn_pkg::REFRACTORY_STEPS_RST,
                           fire_threshold:    lifn_pkg::FIRE_THRESHOLD_RST,
                           kick_amount:       lifn_pkg::KICK_AMOUNT_RST};
        for (int i = 0; i < NEURONS; i++) begin
            membrane_mem[i]    = '0;
            conductance_mem[i] = '0;
            ready_mem[i]       = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_op(DIRECTED_OPS[r].op, DIRECTED_OPS[r].typed, DIRECTED_OPS[r].result);
        end

        // random phases, each under its own register set
        for (int ph = 0; ph < PHASES; ph++) begin
            await_drained();
            load_settings(phase_settings(ph));
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == PRESSURE_PHASE && n == 20) begin
                    hold_req = 1'b1;
                end
                if (ph == PRESSURE_PHASE && n == 45) begin
                    await_drained();
                end
                offer_op(random_op(), PRED, '0);
            end
        end

        // drain and settle
        await_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
